[hw/rtl/flan_pkg.sv]
// ----------------------------------------------------------------------------
// flan_pkg: shared definitions of the stereo flanger
// default sizes, register map, sweep constants and queue port structs
// ----------------------------------------------------------------------------
package flan_pkg;

  // default sizes, handed down from the top level
  localparam int DELAY_LEN_DEF   = 350;
  localparam int SAMPLE_BITS_DEF = 24;

  // sweep arithmetic, q.16 position and q0.16 step
  localparam int FRAC_W = 16;
  localparam int STEP_W = 16;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd131;

  // queue depths between the parts
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_SWEEP_STEP = 1'b0;

  // queue control and status
  typedef struct packed {
    logic push;
    logic pop;
  } flan_qctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } flan_qsts_t;

endpackage

[hw/rtl/flan_fifo.sv]
// ----------------------------------------------------------------------------
// flan_fifo: small register queue
// first-word fall-through queue, head shown while not empty
// ----------------------------------------------------------------------------
module flan_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  flan_pkg::flan_qctl_t   ctl,
  input  logic [WIDTH-1:0]       wdata,
  output flan_pkg::flan_qsts_t   sts,
  output logic [WIDTH-1:0]       rdata
);
  import flan_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign sts.full  = (count == CNT_FULL);
  assign sts.empty = (count == '0);
  assign do_push   = ctl.push && !sts.full;
  assign do_pop    = ctl.pop && !sts.empty;
  assign rdata     = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/flan_front.sv]
// ----------------------------------------------------------------------------
// flan_front: sweep and tap address generation
// works out tap addresses, fraction and entry validity per pair, advances
// the write index and the triangle sweep
// ----------------------------------------------------------------------------
module flan_front #(
  parameter int DELAY_LEN = flan_pkg::DELAY_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [flan_pkg::STEP_W-1:0]      step,
  output logic [$clog2(DELAY_LEN)-1:0]     p1,
  output logic [$clog2(DELAY_LEN)-1:0]     p2,
  output logic [flan_pkg::FRAC_W-1:0]      frac,
  output logic [$clog2(DELAY_LEN)-1:0]     wi,
  output logic                             v1,
  output logic                             v2
);
  import flan_pkg::*;

  localparam int WI_W  = $clog2(DELAY_LEN);
  localparam int IP_W  = $clog2(DELAY_LEN + 1);
  localparam int POS_W = IP_W + FRAC_W + 1;
  localparam logic [WI_W-1:0]   LAST_IDX = WI_W'(DELAY_LEN - 1);
  localparam logic [IP_W:0]     LEN_SUM  = (IP_W + 1)'(DELAY_LEN);
  localparam logic signed [POS_W-1:0] POS_LIMIT =
    POS_W'(longint'(DELAY_LEN) << FRAC_W);
  localparam logic signed [POS_W-1:0] POS_RESET =
    POS_W'(longint'(DELAY_LEN / 2) << FRAC_W);

  logic signed [POS_W-1:0] pos;
  logic                    falling;
  logic                    filled;

  logic                    neg;
  logic [IP_W-1:0]         ipart;
  logic [IP_W:0]           sum;
  logic [IP_W:0]           sum_wrap;
  logic signed [POS_W-1:0] step_ext;
  logic signed [POS_W-1:0] pos_next;
  logic                    turn;

  always_comb begin
    neg      = pos[POS_W-1];
    // a negative sweep taps at the write index with no fraction
    ipart    = neg ? '0 : pos[POS_W-2 -: IP_W];
    frac     = neg ? '0 : pos[FRAC_W-1:0];
    sum      = (IP_W + 1)'(wi) + (IP_W + 1)'(ipart);
    sum_wrap = (sum >= LEN_SUM) ? sum - LEN_SUM : sum;
    p1       = sum_wrap[WI_W-1:0];
    p2       = (p1 == LAST_IDX) ? '0 : p1 + WI_W'(1);
    // entries not yet written since reset read as zero
    v1       = filled || (p1 < wi);
    v2       = filled || (p2 < wi);
    step_ext = $signed({{(POS_W - STEP_W){1'b0}}, step});
    pos_next = falling ? pos - step_ext : pos + step_ext;
    turn     = pos_next[POS_W-1] || (pos_next > POS_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wi      <= '0;
      filled  <= 1'b0;
      pos     <= POS_RESET;
      falling <= 1'b0;
    end else if (accept) begin
      wi      <= (wi == LAST_IDX) ? '0 : wi + WI_W'(1);
      filled  <= filled || (wi == LAST_IDX);
      pos     <= pos_next;
      falling <= falling ^ turn;
    end
  end

endmodule

[hw/rtl/flan_back.sv]
// ----------------------------------------------------------------------------
// flan_back: delay store, interpolation and saturation
// reads both taps, writes the new pair, then interpolates and saturates
// in a two-stage arithmetic pipeline
// ----------------------------------------------------------------------------
module flan_back #(
  parameter int DELAY_LEN   = flan_pkg::DELAY_LEN_DEF,
  parameter int SAMPLE_BITS = flan_pkg::SAMPLE_BITS_DEF,
  parameter int OUT_DEPTH   = flan_pkg::OUT_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               mid_empty,
  output logic                               mid_pop,
  input  logic signed [SAMPLE_BITS-1:0]      left,
  input  logic signed [SAMPLE_BITS-1:0]      right,
  input  logic                               last,
  input  logic [$clog2(DELAY_LEN)-1:0]       p1,
  input  logic [$clog2(DELAY_LEN)-1:0]       p2,
  input  logic [flan_pkg::FRAC_W-1:0]        frac,
  input  logic [$clog2(DELAY_LEN)-1:0]       wi,
  input  logic                               v1,
  input  logic                               v2,
  input  logic                               out_pop,
  output logic                               res_push,
  output logic signed [SAMPLE_BITS-1:0]      res_left,
  output logic signed [SAMPLE_BITS-1:0]      res_right,
  output logic                               res_last
);
  import flan_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int WI_W  = $clog2(DELAY_LEN);
  localparam int OCC_W = $clog2(OUT_DEPTH + 1);
  localparam int DW    = SB + 1;
  localparam int PR_W  = DW + FRAC_W + 1;
  localparam int OFF_W = PR_W - FRAC_W;
  localparam int SUM_W = SB + 3;
  localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(OUT_DEPTH);
  localparam logic signed [PR_W-1:0] RND = PR_W'(longint'(1) << (FRAC_W - 1));
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD2  = 3'b010,
    ST_DIF  = 3'b100
  } seq_state_t;

  seq_state_t state;
  seq_state_t state_next;

  logic [OCC_W-1:0] occ;

  // current pair
  logic signed [SB-1:0] cur_left;
  logic signed [SB-1:0] cur_right;
  logic                 cur_last;
  logic [WI_W-1:0]      cur_p2;
  logic [FRAC_W-1:0]    cur_frac;
  logic [WI_W-1:0]      cur_wi;
  logic                 cur_v1;
  logic                 cur_v2;

  // delay store, left in the upper half
  logic [2*SB-1:0] store [DELAY_LEN];
  logic [WI_W-1:0] rd_addr;
  logic [2*SB-1:0] rd_data;
  logic            mem_we;

  logic signed [SB-1:0] a_left;
  logic signed [SB-1:0] a_right;
  logic signed [SB-1:0] b_left;
  logic signed [SB-1:0] b_right;

  // multiply stage
  logic                 m_vld;
  logic signed [DW-1:0] m_diff_l;
  logic signed [DW-1:0] m_diff_r;
  logic signed [SB-1:0] m_a_l;
  logic signed [SB-1:0] m_a_r;
  logic signed [SB-1:0] m_x_l;
  logic signed [SB-1:0] m_x_r;
  logic                 m_last;
  logic [FRAC_W-1:0]    m_frac;

  // result stage
  logic                   p_vld;
  logic signed [PR_W-1:0] p_prod_l;
  logic signed [PR_W-1:0] p_prod_r;
  logic signed [SB-1:0]   p_a_l;
  logic signed [SB-1:0]   p_a_r;
  logic signed [SB-1:0]   p_x_l;
  logic signed [SB-1:0]   p_x_r;
  logic                   p_last;

  logic signed [PR_W-1:0]  rnd_l;
  logic signed [PR_W-1:0]  rnd_r;
  logic signed [OFF_W-1:0] off_l;
  logic signed [OFF_W-1:0] off_r;
  logic signed [SUM_W-1:0] y_l;
  logic signed [SUM_W-1:0] y_r;
  logic signed [FRAC_W:0]  f_s;

  // ---- sequencer ----
  assign mid_pop = (state == ST_IDLE) && !mid_empty && (occ < OCC_MAX);
  assign mem_we  = (state == ST_DIF);
  assign rd_addr = (state == ST_IDLE) ? p1 : cur_p2;

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = mid_pop ? ST_RD2 : ST_IDLE;
      ST_RD2:  state_next = ST_DIF;
      ST_DIF:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      occ   <= '0;
    end else begin
      state <= state_next;
      case ({mid_pop, out_pop})
        2'b10:   occ <= occ + OCC_W'(1);
        2'b01:   occ <= occ - OCC_W'(1);
        default: occ <= occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      cur_left  <= left;
      cur_right <= right;
      cur_last  <= last;
      cur_p2    <= p2;
      cur_frac  <= frac;
      cur_wi    <= wi;
      cur_v1    <= v1;
      cur_v2    <= v2;
    end
  end

  // ---- store access ----
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[cur_wi] <= {cur_left, cur_right};
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_RD2) begin
      a_left  <= cur_v1 ? $signed(rd_data[2*SB-1:SB]) : '0;
      a_right <= cur_v1 ? $signed(rd_data[SB-1:0]) : '0;
    end
  end

  assign b_left  = cur_v2 ? $signed(rd_data[2*SB-1:SB]) : '0;
  assign b_right = cur_v2 ? $signed(rd_data[SB-1:0]) : '0;

  // ---- arithmetic pipeline ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
      p_vld <= 1'b0;
    end else begin
      m_vld <= mem_we;
      p_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      m_diff_l <= DW'(b_left) - DW'(a_left);
      m_diff_r <= DW'(b_right) - DW'(a_right);
      m_a_l    <= a_left;
      m_a_r    <= a_right;
      m_x_l    <= cur_left;
      m_x_r    <= cur_right;
      m_last   <= cur_last;
      m_frac   <= cur_frac;
    end
  end

  assign f_s = $signed({1'b0, m_frac});

  always_ff @(posedge clk) begin
    if (m_vld) begin
      p_prod_l <= m_diff_l * f_s;
      p_prod_r <= m_diff_r * f_s;
      p_a_l    <= m_a_l;
      p_a_r    <= m_a_r;
      p_x_l    <= m_x_l;
      p_x_r    <= m_x_r;
      p_last   <= m_last;
    end
  end

  // delayed = a + floor((diff*f + half) / 2^16), then input added and clipped
  always_comb begin
    rnd_l = p_prod_l + RND;
    rnd_r = p_prod_r + RND;
    off_l = $signed(rnd_l[PR_W-1:FRAC_W]);
    off_r = $signed(rnd_r[PR_W-1:FRAC_W]);
    y_l   = SUM_W'(p_x_l) + SUM_W'(p_a_l) + SUM_W'(off_l);
    y_r   = SUM_W'(p_x_r) + SUM_W'(p_a_r) + SUM_W'(off_r);
    if (y_l > SAT_MAX) begin
      res_left = SAT_MAX[SB-1:0];
    end else if (y_l < SAT_MIN) begin
      res_left = SAT_MIN[SB-1:0];
    end else begin
      res_left = y_l[SB-1:0];
    end
    if (y_r > SAT_MAX) begin
      res_right = SAT_MAX[SB-1:0];
    end else if (y_r < SAT_MIN) begin
      res_right = SAT_MIN[SB-1:0];
    end else begin
      res_right = y_r[SB-1:0];
    end
  end

  assign res_push = p_vld;
  assign res_last = p_last;

  // ---- checks ----
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_MAX)
    else $error("result credit count above output queue depth");

  a_res_credit: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (occ != '0))
    else $error("result pushed without a reserved slot");

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> ((p1 < DELAY_LEN) && (p2 < DELAY_LEN) && (wi < DELAY_LEN)))
    else $error("tap or write address outside the delay store");

  a_dif_to_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIF) |=> (m_vld && (state == ST_IDLE)))
    else $error("pair lost between store access and multiply");

endmodule

[hw/rtl/stereo_interpolating_flanger_top.sv]
// ----------------------------------------------------------------------------
// stereo_interpolating_flanger_top: stereo flanger with interpolated tap
// a pushed pair passes the mid queue, both tap reads, the store write, the multiply and
// result stages and the result queue before empty goes low; the back starts a pair only
// from idle, set by the delay store's single read port (two tap reads, then the write of
// the new pair); from idle a burst of up to 3 enters back to back, the first going straight on to the back
// reset: synchronous, clears queues, write index, sweep to half length rising,
// sweep step to 131; the store needs no clearing pass, a fill flag masks it
// ----------------------------------------------------------------------------
module stereo_interpolating_flanger_top #(
  parameter int DELAY_LEN   = flan_pkg::DELAY_LEN_DEF,
  parameter int SAMPLE_BITS = flan_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input queue side
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [SAMPLE_BITS-1:0]        left_in,
  input  logic signed [SAMPLE_BITS-1:0]        right_in,
  input  logic                                 block_last_in,
  // result queue side
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [SAMPLE_BITS-1:0]        left_out,
  output logic signed [SAMPLE_BITS-1:0]        right_out,
  output logic                                 block_last_out,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [flan_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [flan_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [flan_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import flan_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int WI_W  = $clog2(DELAY_LEN);
  // mid queue entry: samples, flag, taps, fraction, write index, valid bits
  localparam int MID_W = 2 * SB + 1 + 3 * WI_W + FRAC_W + 2;
  localparam int OUT_W = 2 * SB + 1;

  // ---- configuration register ----
  logic [STEP_W-1:0] sweep_step;
  logic              cfg_wr;

  assign pready = 1'b1;
  // word index sits at address bit 2, low bits are the byte offset
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_step <= STEP_RESET;
    end else if (cfg_wr && (paddr[2] == REG_SWEEP_STEP)) begin
      sweep_step <= pwdata[STEP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SWEEP_STEP) begin
      prdata = CFG_DATA_W'(sweep_step);
    end
  end

  // ---- front: accept a transaction and work out its taps ----
  logic            in_acc;
  logic [WI_W-1:0] f_p1;
  logic [WI_W-1:0] f_p2;
  logic [FRAC_W-1:0] f_frac;
  logic [WI_W-1:0] f_wi;
  logic            f_v1;
  logic            f_v2;

  flan_qctl_t      mid_ctl;
  flan_qsts_t      mid_sts;
  logic [MID_W-1:0] mid_wdata;
  logic [MID_W-1:0] mid_rdata;

  assign full   = mid_sts.full;
  assign in_acc = push && !mid_sts.full;

  flan_front #(
    .DELAY_LEN (DELAY_LEN)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (in_acc),
    .step   (sweep_step),
    .p1     (f_p1),
    .p2     (f_p2),
    .frac   (f_frac),
    .wi     (f_wi),
    .v1     (f_v1),
    .v2     (f_v2)
  );

  assign mid_wdata = {left_in, right_in, block_last_in, f_p1, f_p2, f_frac, f_wi,
                      f_v1, f_v2};

  // ---- queue between front and back ----
  logic                 back_pop;
  logic signed [SB-1:0] h_left;
  logic signed [SB-1:0] h_right;
  logic                 h_last;
  logic [WI_W-1:0]      h_p1;
  logic [WI_W-1:0]      h_p2;
  logic [FRAC_W-1:0]    h_frac;
  logic [WI_W-1:0]      h_wi;
  logic                 h_v1;
  logic                 h_v2;

  assign mid_ctl.push = in_acc;
  assign mid_ctl.pop  = back_pop;

  flan_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mid_ctl),
    .wdata (mid_wdata),
    .sts   (mid_sts),
    .rdata (mid_rdata)
  );

  assign {h_left, h_right, h_last, h_p1, h_p2, h_frac, h_wi, h_v1, h_v2} = mid_rdata;

  // ---- back: store access, interpolation, saturation ----
  flan_qctl_t           out_ctl;
  flan_qsts_t           out_sts;
  logic                 out_acc;
  logic                 res_push;
  logic signed [SB-1:0] res_left;
  logic signed [SB-1:0] res_right;
  logic                 res_last;
  logic [OUT_W-1:0]     out_rdata;

  assign out_acc = pop && !out_sts.empty;

  flan_back #(
    .DELAY_LEN   (DELAY_LEN),
    .SAMPLE_BITS (SAMPLE_BITS),
    .OUT_DEPTH   (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_sts.empty),
    .mid_pop   (back_pop),
    .left      (h_left),
    .right     (h_right),
    .last      (h_last),
    .p1        (h_p1),
    .p2        (h_p2),
    .frac      (h_frac),
    .wi        (h_wi),
    .v1        (h_v1),
    .v2        (h_v2),
    .out_pop   (out_acc),
    .res_push  (res_push),
    .res_left  (res_left),
    .res_right (res_right),
    .res_last  (res_last)
  );

  // ---- result queue, slots reserved by the back before a pair starts ----
  assign out_ctl.push = res_push;
  assign out_ctl.pop  = pop;

  flan_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .ctl   (out_ctl),
    .wdata ({res_left, res_right, res_last}),
    .sts   (out_sts),
    .rdata (out_rdata)
  );

  assign empty = out_sts.empty;
  assign {left_out, right_out, block_last_out} = out_rdata;

endmodule
